// ===== rtl/lru_tc_pkg.sv =====
package lru_tc_pkg;

  localparam int ENTRIES_DEF      = 64;
  localparam int TILE_ID_BITS_DEF = 32;
  localparam int HANDLE_BITS_DEF  = 32;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_INVAL  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TOUCH,
    ST_SHIFT,
    ST_CLOSE,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] key_media;
    logic [31:0] key_tile;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] payload_out;
    logic        evicted;
    logic [6:0]  removed_count;
  } out_item_t;

  typedef struct packed {
    logic kv_we;
    logic rank_we;
    logic shift_we;
  } mem_we_t;

endpackage

// ===== rtl/lru_tc_store.sv =====
module lru_tc_store
  import lru_tc_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int TILE_ID_BITS = TILE_ID_BITS_DEF,
  parameter int HANDLE_BITS  = HANDLE_BITS_DEF,
  localparam int IW = $clog2(ENTRIES),
  localparam int KW = 64 + TILE_ID_BITS + HANDLE_BITS
) (
  input  logic          clk,
  input  mem_we_t       we,
  input  logic [IW-1:0] kv_addr,
  input  logic [KW-1:0] kv_wdata,
  output logic [KW-1:0] kv_rdata,
  input  logic [IW-1:0] rank_raddr,
  input  logic [IW-1:0] rank_waddr,
  input  logic [IW-1:0] rank_wdata,
  output logic [IW-1:0] rank_rdata,
  input  logic [IW-1:0] shift_raddr,
  input  logic [IW-1:0] shift_waddr,
  input  logic [IW-1:0] shift_wdata,
  output logic [IW-1:0] shift_rdata
);

  logic [KW-1:0] kv_mem    [ENTRIES];
  logic [IW-1:0] rank_mem  [ENTRIES];
  logic [IW-1:0] shift_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we.kv_we) begin
      kv_mem[kv_addr] <= kv_wdata;
    end
    kv_rdata <= kv_mem[kv_addr];
  end

  always_ff @(posedge clk) begin
    if (we.rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rdata <= rank_mem[rank_raddr];
  end

  // Holds, per age rank, how many removed entries were more recent.
  always_ff @(posedge clk) begin
    if (we.shift_we) begin
      shift_mem[shift_waddr] <= shift_wdata;
    end
    shift_rdata <= shift_mem[shift_raddr];
  end

endmodule

// ===== rtl/lru_tc_ctrl.sv =====
module lru_tc_ctrl
  import lru_tc_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int TILE_ID_BITS = TILE_ID_BITS_DEF,
  parameter int HANDLE_BITS  = HANDLE_BITS_DEF,
  localparam int IW = $clog2(ENTRIES),
  localparam int KW = 64 + TILE_ID_BITS + HANDLE_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_item_t      in_item,
  output logic          out_strobe,
  output out_item_t     out_item,
  output mem_we_t       we,
  output logic [IW-1:0] kv_addr,
  output logic [KW-1:0] kv_wdata,
  input  logic [KW-1:0] kv_rdata,
  output logic [IW-1:0] rank_raddr,
  output logic [IW-1:0] rank_waddr,
  output logic [IW-1:0] rank_wdata,
  input  logic [IW-1:0] rank_rdata,
  output logic [IW-1:0] shift_raddr,
  output logic [IW-1:0] shift_waddr,
  output logic [IW-1:0] shift_wdata,
  input  logic [IW-1:0] shift_rdata
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r;
  logic                    d1_vld_r, d2_vld_r;
  logic [IW-1:0]           d1_idx_r, d2_idx_r, d2_rank_r;
  logic [ENTRIES-1:0]      valid_r, rmask_r;
  logic [CW-1:0]           fill_r, removed_r, cum_r;
  logic                    hit_r, free_found_r, age_all_r, evict_r;
  cmd_t                    cmd_r;
  logic [63:0]             media_r;
  logic [TILE_ID_BITS-1:0] tile_r;
  logic [HANDLE_BITS-1:0]  handle_r, hhandle_r;
  logic [IW-1:0]           slot_r, hrank_r, lru_r, free_r;

  logic                    accept, issue, pass_end, ins_end;
  logic [IW-1:0]           ins_slot;
  logic [63:0]             rd_media;
  logic [TILE_ID_BITS-1:0] rd_tile;
  logic [HANDLE_BITS-1:0]  rd_handle;
  logic                    rd_valid;

  assign accept = start && (state_r == ST_IDLE);
  assign {rd_media, rd_tile, rd_handle} = kv_rdata;
  assign rd_valid = valid_r[d1_idx_r];
  assign issue = (cnt_r < FULL) &&
                 (state_r == ST_SCAN || state_r == ST_TOUCH || state_r == ST_CLOSE);
  assign pass_end = (cnt_r == FULL) && !d1_vld_r && !d2_vld_r;
  assign ins_end = (state_r == ST_SCAN) && pass_end && (cmd_r == CMD_INSERT);
  assign ins_slot = hit_r ? slot_r : ((fill_r == FULL) ? lru_r : free_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_item.cmd == CMD_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pass_end) begin
          case (cmd_r)
            CMD_LOOKUP: state_nxt = hit_r ? ST_TOUCH : ST_DONE;
            CMD_INSERT: state_nxt = ST_TOUCH;
            CMD_INVAL:  state_nxt = (removed_r != '0) ? ST_SHIFT : ST_DONE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_TOUCH: if (pass_end) state_nxt = ST_DONE;
      ST_SHIFT: if (cnt_r == FULL) state_nxt = ST_CLOSE;
      ST_CLOSE: if (pass_end) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state_r != ST_IDLE);
    out_strobe  = (state_r == ST_DONE);
    out_item.hit           = hit_r;
    out_item.payload_out   = (cmd_r == CMD_LOOKUP && hit_r) ? 32'(hhandle_r) : 32'd0;
    out_item.evicted       = evict_r;
    out_item.removed_count = 7'(removed_r);

    we.kv_we    = ins_end;
    kv_addr     = ins_end ? ins_slot : cnt_r[IW-1:0];
    kv_wdata    = {media_r, tile_r, handle_r};

    rank_raddr  = cnt_r[IW-1:0];
    shift_raddr = rank_rdata;
    shift_waddr = cnt_r[IW-1:0];
    shift_wdata = cum_r[IW-1:0];
    we.shift_we = (state_r == ST_SHIFT) && (cnt_r < FULL);

    we.rank_we  = 1'b0;
    rank_waddr  = d1_idx_r;
    rank_wdata  = '0;
    if (state_r == ST_TOUCH && d1_vld_r) begin
      if (d1_idx_r == slot_r) begin
        we.rank_we = 1'b1;
      end else if (rd_valid && (age_all_r || rank_rdata < hrank_r)) begin
        we.rank_we = 1'b1;
        rank_wdata = rank_rdata + 1'b1;
      end
    end else if (state_r == ST_CLOSE && d2_vld_r) begin
      we.rank_we = valid_r[d2_idx_r];
      rank_waddr = d2_idx_r;
      rank_wdata = d2_rank_r - shift_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      d1_vld_r <= 1'b0;
      d2_vld_r <= 1'b0;
      valid_r  <= '0;
      fill_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      if (state_r != state_nxt) begin
        cnt_r <= '0;
      end else if (issue || we.shift_we) begin
        cnt_r <= cnt_r + 1'b1;
      end
      d1_vld_r <= issue;
      d2_vld_r <= d1_vld_r && (state_r == ST_CLOSE);
      if (accept && in_item.cmd == CMD_CLEAR) begin
        valid_r <= '0;
        fill_r  <= '0;
      end
      if (state_r == ST_SCAN && d1_vld_r && cmd_r == CMD_INVAL &&
          rd_valid && rd_media == media_r) begin
        valid_r[d1_idx_r] <= 1'b0;
      end
      if (state_r == ST_SCAN && pass_end && cmd_r == CMD_INVAL) begin
        fill_r <= fill_r - removed_r;
      end
      if (ins_end && !hit_r) begin
        valid_r[ins_slot] <= 1'b1;
        if (fill_r != FULL) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    d1_idx_r  <= cnt_r[IW-1:0];
    d2_idx_r  <= d1_idx_r;
    d2_rank_r <= rank_rdata;
    if (accept) begin
      cmd_r        <= in_item.cmd;
      media_r      <= in_item.key_media;
      tile_r       <= TILE_ID_BITS'(in_item.key_tile);
      handle_r     <= HANDLE_BITS'(in_item.payload);
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      age_all_r    <= 1'b0;
      evict_r      <= 1'b0;
      rmask_r      <= '0;
      cum_r        <= '0;
      lru_r        <= '0;
      free_r       <= '0;
      slot_r       <= '0;
      hrank_r      <= '0;
      hhandle_r    <= '0;
      removed_r    <= (in_item.cmd == CMD_CLEAR) ? fill_r : '0;
    end
    if (state_r == ST_SCAN && d1_vld_r) begin
      if (cmd_r == CMD_INVAL) begin
        if (rd_valid && rd_media == media_r) begin
          removed_r          <= removed_r + 1'b1;
          rmask_r[rank_rdata] <= 1'b1;
        end
      end else begin
        if (rd_valid && rd_media == media_r && rd_tile == tile_r) begin
          hit_r     <= 1'b1;
          slot_r    <= d1_idx_r;
          hrank_r   <= rank_rdata;
          hhandle_r <= rd_handle;
        end
        if (rd_valid && CW'(rank_rdata) == fill_r - 1'b1) begin
          lru_r <= d1_idx_r;
        end
        if (!rd_valid && !free_found_r) begin
          free_r       <= d1_idx_r;
          free_found_r <= 1'b1;
        end
      end
    end
    if (ins_end) begin
      slot_r    <= ins_slot;
      age_all_r <= !hit_r;
      evict_r   <= !hit_r && (fill_r == FULL);
    end
    // Running count of removed ranks below the rank being written.
    if (we.shift_we) begin
      cum_r <= cum_r + CW'(rmask_r[cnt_r[IW-1:0]]);
    end
  end

endmodule

// ===== rtl/lru_tile_cache_group_invalidate_top.sv =====
// Channel   Ports                       Beat taken when
// input     start, busy, in_item        start high and busy low at a clock edge
// result    out_strobe, out_item        out_strobe high (one cycle, no backpressure)
//
// A lookup miss makes one key scan through the entry memory; a lookup hit and every
// insert add a second pass to age the ranks. Invalidate with removals runs a scan,
// a rank-shift table sweep, and a rank close-up pass. Clear goes straight to the result.
// Reset (synchronous, rst_n low) empties the cache at once; no clearing pass.
// busy rises after the accepted beat and stays high through the result cycle.
module lru_tile_cache_group_invalidate_top
  import lru_tc_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int TILE_ID_BITS = TILE_ID_BITS_DEF,
  parameter int HANDLE_BITS  = HANDLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int IW = $clog2(ENTRIES);
  localparam int KW = 64 + TILE_ID_BITS + HANDLE_BITS;

  mem_we_t       we;
  logic [IW-1:0] kv_addr, rank_raddr, rank_waddr, rank_wdata, rank_rdata;
  logic [IW-1:0] shift_raddr, shift_waddr, shift_wdata, shift_rdata;
  logic [KW-1:0] kv_wdata, kv_rdata;

  lru_tc_ctrl #(
    .ENTRIES(ENTRIES), .TILE_ID_BITS(TILE_ID_BITS), .HANDLE_BITS(HANDLE_BITS)
  ) u_ctrl (
    .clk, .rst_n, .start, .busy, .in_item, .out_strobe, .out_item, .we,
    .kv_addr, .kv_wdata, .kv_rdata,
    .rank_raddr, .rank_waddr, .rank_wdata, .rank_rdata,
    .shift_raddr, .shift_waddr, .shift_wdata, .shift_rdata
  );

  lru_tc_store #(
    .ENTRIES(ENTRIES), .TILE_ID_BITS(TILE_ID_BITS), .HANDLE_BITS(HANDLE_BITS)
  ) u_store (
    .clk, .we,
    .kv_addr, .kv_wdata, .kv_rdata,
    .rank_raddr, .rank_waddr, .rank_wdata, .rank_rdata,
    .shift_raddr, .shift_waddr, .shift_wdata, .shift_rdata
  );

endmodule
